// File: rtl/core/bfa_pkg.sv
// package: shared types, constants and helpers of the bitmap frame allocator
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  // default geometry
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_FRAMES = 32768;

  // frame numbers derived from 32-bit addresses, with room for range ends
  localparam int FRAME_W = 26;
  localparam int CNT_W   = 16;

  // operation codes
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_RESERVE = 3'd2;
  localparam logic [2:0] OP_ALLOC   = 3'd3;
  localparam logic [2:0] OP_FREE    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // decoded request handed from front to back
  typedef struct packed {
    logic [2:0]         op;
    logic [FRAME_W-1:0] fa;     // first frame
    logic [FRAME_W-1:0] fb;     // frame after the range
    logic [FRAME_W-1:0] ef;     // clamped end frame of a free region
    logic               empty;  // free region with end at or below start
  } bfa_cmd_t;

  // saturating add of a small amount to a count
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [5:0] k,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + {{(CNT_W-5){1'b0}}, k};
    return (sum > {1'b0, cap}) ? cap : sum[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/bfa_front.sv
// front end: accepts requests, decodes frame ranges, queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module bfa_front #(
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [63:0]      s_tdata,
  input  wire logic [2:0]       s_tuser,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output bfa_pkg::bfa_cmd_t     q_cmd
);
  import bfa_pkg::*;

  localparam int SH = $clog2(PAGE_BYTES);

  logic [31:0]        s_addr, e_addr;
  logic [32:0]        e_up, diff_up;
  logic [FRAME_W-1:0] f_s, f_e, f_eup, n_pages, max_f;
  bfa_cmd_t           cmd;
  bfa_cmd_t           slots [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         fill;
  logic               push;

  assign s_addr = s_tdata[31:0];
  assign e_addr = s_tdata[63:32];
  assign max_f  = FRAME_W'(MAX_FRAMES);

  // frame arithmetic on the incoming request
  always_comb begin
    f_s     = FRAME_W'(s_addr >> SH);
    f_e     = FRAME_W'(e_addr >> SH);
    e_up    = {1'b0, e_addr} + 33'(PAGE_BYTES - 1);
    f_eup   = FRAME_W'(e_up >> SH);
    diff_up = {1'b0, e_addr - s_addr} + 33'(PAGE_BYTES - 1);
    n_pages = FRAME_W'(diff_up >> SH);
    cmd.op    = s_tuser;
    cmd.fa    = f_s;
    cmd.ef    = (f_e > max_f) ? max_f : f_e;
    cmd.empty = (e_addr <= s_addr);
    cmd.fb    = (s_tuser == OP_ADD) ? f_s + n_pages : f_eup;
  end

  // two-entry request queue
  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bfa_back.sv
// back end: used map memory, word-wide range walks and allocation scan, result register
`timescale 1ns / 1ps
`default_nettype none
module bfa_back #(
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  wire bfa_pkg::bfa_cmd_t q_cmd,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata
);
  import bfa_pkg::*;

  localparam int SH        = $clog2(PAGE_BYTES);
  localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
  localparam int WW        = $clog2(MAP_WORDS);
  localparam int LW        = $clog2(MAX_FRAMES + 1);
  localparam int CAP       = (MAX_FRAMES < 65535) ? MAX_FRAMES : 65535;

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [31:0]        mem [MAP_WORDS];
  logic [31:0]        rdata;
  logic [2:0]         state, state_next;
  logic [WW-1:0]      w, wlast;
  logic [4:0]         lo_off, hi_off;
  logic               w_first;
  logic [2:0]         op;
  logic               fill_reply;
  logic [LW-1:0]      limit;
  logic [CNT_W-1:0]   used_total, usable_total, cap_c;
  logic [31:0]        res_addr;
  logic [1:0]         res_status;

  logic [FRAME_W-1:0] lim_ext, new_lim, hi_sel, lo_sel, hi_m1;
  logic               go_walk;
  logic [31:0]        mask, cand, wdata, onehot;
  logic [4:0]         bsel;
  logic               we, last_word;
  logic [5:0]         k;

  assign cap_c   = CNT_W'(CAP);
  assign lim_ext = FRAME_W'(limit);

  // range setup for a popped request
  always_comb begin
    new_lim = (q_cmd.ef > lim_ext) ? q_cmd.ef : lim_ext;
    lo_sel  = q_cmd.fa;
    hi_sel  = q_cmd.fb;
    go_walk = 1'b0;
    unique case (q_cmd.op)
      OP_ADD: begin
        hi_sel  = (q_cmd.fb < new_lim) ? q_cmd.fb : new_lim;
        go_walk = !q_cmd.empty && (q_cmd.fa < hi_sel);
      end
      OP_RESERVE: begin
        hi_sel  = (q_cmd.fb < FRAME_W'(MAX_FRAMES)) ? q_cmd.fb : FRAME_W'(MAX_FRAMES);
        go_walk = (q_cmd.fa < hi_sel);
      end
      OP_ALLOC: begin
        lo_sel  = FRAME_W'(1);
        hi_sel  = lim_ext;
        go_walk = (lim_ext > FRAME_W'(1));
      end
      OP_FREE: begin
        hi_sel  = q_cmd.fa + FRAME_W'(1);
        go_walk = (q_cmd.fa < lim_ext);
      end
      default: go_walk = 1'b0;
    endcase
    hi_m1 = hi_sel - FRAME_W'(1);
  end

  // per-word mask and update
  always_comb begin
    mask = ({32{1'b1}} << (w_first ? lo_off : 5'd0))
         & ({32{1'b1}} >> ((w == wlast) ? (5'd31 - hi_off) : 5'd0));
    last_word = (w == wlast);
    cand  = mask & ~rdata;
    bsel  = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) bsel = 5'(i);
    end
    onehot = 32'd1 << bsel;
    k      = 6'($countones(cand));
    unique case (op)
      OP_ADD:     wdata = rdata & ~mask;
      OP_RESERVE: wdata = rdata | mask;
      OP_ALLOC:   wdata = (cand != 32'd0) ? (rdata | onehot) : rdata;
      default:    wdata = rdata & ~mask;
    endcase
    we = (state == S_FILL) || (state == S_MOD);
  end

  // map memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[w] <= (state == S_FILL) ? {32{1'b1}} : wdata;
    if (state == S_RD) rdata <= mem[w];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL: if (w == WW'(MAP_WORDS - 1)) state_next = fill_reply ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_INIT) state_next = S_FILL;
          else if (go_walk)       state_next = S_RD;
          else                    state_next = S_DONE;
        end
      end
      S_RD:  state_next = S_MOD;
      S_MOD: begin
        if (last_word || (op == OP_ALLOC && cand != 32'd0)) state_next = S_DONE;
        else                                               state_next = S_RD;
      end
      S_DONE: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      w            <= '0;
      fill_reply   <= 1'b0;
      limit        <= '0;
      used_total   <= '0;
      usable_total <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_FILL: w <= w + WW'(1);
        S_IDLE: begin
          if (q_valid) begin
            op         <= q_cmd.op;
            res_addr   <= 32'd0;
            res_status <= (q_cmd.op == OP_ALLOC) ? ST_NO_FREE
                        : (q_cmd.op == OP_FREE && !go_walk) ? ST_INVALID : ST_OK;
            w          <= WW'(lo_sel >> 5);
            wlast      <= WW'(hi_m1 >> 5);
            lo_off     <= lo_sel[4:0];
            hi_off     <= hi_m1[4:0];
            w_first    <= 1'b1;
            if (q_cmd.op == OP_INIT) begin
              w            <= '0;
              fill_reply   <= 1'b1;
              limit        <= '0;
              used_total   <= '0;
              usable_total <= '0;
            end
            if (q_cmd.op == OP_ADD) limit <= LW'(new_lim);
          end
        end
        S_RD: ;
        S_MOD: begin
          w       <= w + WW'(1);
          w_first <= 1'b0;
          unique case (op)
            OP_ADD:     usable_total <= sat_add(usable_total, 6'($countones(mask)), cap_c);
            OP_RESERVE: used_total   <= sat_add(used_total, k, cap_c);
            OP_ALLOC: begin
              if (cand != 32'd0) begin
                used_total <= sat_add(used_total, 6'd1, cap_c);
                res_addr   <= 32'({w, bsel}) << SH;
                res_status <= ST_OK;
              end
            end
            default: if (used_total != '0) used_total <= used_total - CNT_W'(1);
          endcase
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            fill_reply <= 1'b0;
            m_tdata    <= {6'd0, usable_total, used_total, res_status, res_addr};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bitmap_frame_allocator.sv
// top level: bitmap page frame allocator
`timescale 1ns / 1ps
`default_nettype none
// Bitmap page frame allocator. One request is carried out at a time by the
// back end; a two-entry queue behind the input lets the next requests enter
// meanwhile. Range, allocate and free requests walk the used map one 32-bit
// word at a time (memory read, then modify and write): free touches one word,
// allocate up to ceil(frame_limit / 32) words. Init and the pass after reset
// rewrite the whole map, during which no request is carried out. PAGE_BYTES
// must be a power of two.
module bitmap_frame_allocator #(
  parameter int PAGE_BYTES = bfa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // range_start, range_end
  input  wire logic [2:0]  s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // frame_address, status, used_count, usable_count
);
  import bfa_pkg::*;

  logic     q_valid, q_pop;
  bfa_cmd_t q_cmd;

  bfa_front #(.PAGE_BYTES(PAGE_BYTES), .MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_valid, .q_pop, .q_cmd
  );

  bfa_back #(.PAGE_BYTES(PAGE_BYTES), .MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .m_tvalid, .m_tready, .m_tdata
  );

endmodule
`default_nettype wire

// File: rtl/core/bfa_checker.sv
// checker on the top level ports, with its bind
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);
  // stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
  // failed request returns no address
  a_noaddr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0) else $error("addr on error");
  // address aligned to 256 bytes (low eight bits zero)
  a_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] == 8'd0) else $error("unaligned address");
endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
